/* design/eulr_pkg.sv */
// ---------------------------------------------------------------------------
// eulr_pkg
// Shared types, constants and fixed-point helpers for the Euler angle to
// rotation matrix pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package eulr_pkg;

  // Default number of CORDIC iterations and the size of the arctangent table.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;
  localparam int TABLE_IDX_W       = $clog2(TABLE_LEN);

  // CORDIC datapath width: Q1.30 with headroom for growth and folding.
  localparam int CW = 33;

  // Starting x of the rotator: the inverse CORDIC gain in Q1.30.
  localparam logic signed [CW-1:0] X_INIT = 33'sd652032874;

  // Half a turn in units of 2^-32 turn and the quarter-turn fold limit in angle counts.
  localparam logic signed [CW-1:0] HALF_TURN   = 33'sd2147483648;
  localparam logic signed [15:0]   QUARTER_CNT = 16'sd16384;

  // Unity in Q1.14.
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // Sine and cosine of one angle, both Q1.14.
  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [31:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
    logic signed [31:0] r;
    unique case (idx)
      5'd0:    r = 32'sd536870912;
      5'd1:    r = 32'sd316933406;
      5'd2:    r = 32'sd167458907;
      5'd3:    r = 32'sd85004756;
      5'd4:    r = 32'sd42667331;
      5'd5:    r = 32'sd21354465;
      5'd6:    r = 32'sd10679838;
      5'd7:    r = 32'sd5340245;
      5'd8:    r = 32'sd2670163;
      5'd9:    r = 32'sd1335087;
      5'd10:   r = 32'sd667544;
      5'd11:   r = 32'sd333772;
      5'd12:   r = 32'sd166886;
      5'd13:   r = 32'sd83443;
      5'd14:   r = 32'sd41721;
      5'd15:   r = 32'sd20860;
      5'd16:   r = 32'sd10430;
      5'd17:   r = 32'sd5215;
      5'd18:   r = 32'sd2607;
      5'd19:   r = 32'sd1303;
      5'd20:   r = 32'sd651;
      5'd21:   r = 32'sd325;
      5'd22:   r = 32'sd162;
      5'd23:   r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Clamp a value to the closed range [-1.0, +1.0] in Q1.14.
  function automatic logic signed [15:0] sat_q14(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd16384) begin
      r = ONE_Q14;
    end else if (v < -20'sd16384) begin
      r = -ONE_Q14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Round Q1.30 to Q1.14, half up, then clamp.
  function automatic logic signed [15:0] rnd_q30(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    t = (CW+1)'(v) + 34'sd32768;
    return sat_q14(20'($signed(t[CW:16])));
  endfunction

  // Round a Q2.28 product to Q1.14, half up, then clamp.
  function automatic logic signed [15:0] rnd_q28(input logic signed [29:0] v);
    logic signed [30:0] t;
    t = 31'(v) + 31'sd8192;
    return sat_q14(20'($signed(t[30:14])));
  endfunction

  // Round a Q3.42 sum to Q1.14, half up, then clamp.
  function automatic logic signed [15:0] rnd_q42(input logic signed [45:0] v);
    logic signed [46:0] t;
    t = 47'(v) + 47'sd134217728;
    return sat_q14(20'($signed(t[46:28])));
  endfunction

endpackage

`default_nettype wire

/* design/euler_to_rotation_matrix.sv */
// ---------------------------------------------------------------------------
// euler_to_rotation_matrix
// Converts roll, pitch and yaw binary angles into the z-y-x rotation matrix
// R = Rz(yaw) * Ry(pitch) * Rx(roll), each element Q1.14 clamped to +/-1.0.
//
// Input channel: roll_angle, pitch_angle and yaw_angle are taken as one word
// at every rising edge where start is high and busy is low. busy is always
// low, so a new word may be offered in every cycle.
// Output channel: the nine elements m00..m22 are valid for exactly one cycle
// while done is high; the receiver has no way to hold them off and must take
// them in that cycle.
// Pipeline: a word passes through the fold register, the CORDIC iteration
// pipeline (one stage per iteration), the sign fix and rounding registers
// and then the product pipeline of pair products, triple products, sums and
// rounding. Throughput is one word per cycle. Reset clears every valid bit,
// so nothing in flight is delivered and done stays low until a new word has
// passed through. The block holds no state beyond the pipeline itself.
// ---------------------------------------------------------------------------
`default_nettype none

module euler_to_rotation_matrix
  import eulr_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic               done,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22
);

  logic               accept;
  logic signed [15:0] angle [3];
  logic               trig_valid;
  trig_t              trig  [3];

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign angle[0] = roll_angle;
  assign angle[1] = pitch_angle;
  assign angle[2] = yaw_angle;

  // Sine and cosine of all three angles.
  eulr_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .vin  (accept),
    .angle(angle),
    .vout (trig_valid),
    .trig (trig)
  );

  // Matrix products and output register.
  eulr_mat u_mat (
    .clk (clk),
    .rst (rst),
    .vin (trig_valid),
    .trig(trig),
    .done(done),
    .m00 (m00),
    .m01 (m01),
    .m02 (m02),
    .m10 (m10),
    .m11 (m11),
    .m12 (m12),
    .m20 (m20),
    .m21 (m21),
    .m22 (m22)
  );

endmodule

`default_nettype wire

/* design/eulr_cordic.sv */
// ---------------------------------------------------------------------------
// eulr_cordic
// Three parallel pipelined CORDIC rotators giving sine and cosine of the
// roll, pitch and yaw angles, one iteration per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module eulr_cordic
  import eulr_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vin,
  input  logic signed [15:0] angle [3],
  output logic               vout,
  output trig_t              trig  [3]
);

  // Valid bits: fold stage, one per iteration, the sign-fix stage and rounding.
  localparam int NV = CORDIC_STAGES + 3;

  logic v_q [NV];

  // Valid bits travel alongside the data and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NV; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= vin;
      for (int k = 1; k < NV; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  assign vout = v_q[NV-1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [CW-1:0] z_fold;
    logic                 flip_in;
    logic signed [CW-1:0] x_q    [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_q    [CORDIC_STAGES+1];
    logic signed [CW-1:0] z_q    [CORDIC_STAGES+1];
    logic                 flip_q [CORDIC_STAGES+1];
    logic signed [CW-1:0] xf_q;
    logic signed [CW-1:0] yf_q;
    trig_t                trig_q;

    // Widen the angle and fold it into the right half plane.
    always_comb begin
      z_fold  = CW'(angle[l]) <<< 16;
      flip_in = 1'b0;
      if (angle[l] > QUARTER_CNT) begin
        z_fold  = z_fold - HALF_TURN;
        flip_in = 1'b1;
      end else if (angle[l] < -QUARTER_CNT) begin
        z_fold  = z_fold + HALF_TURN;
        flip_in = 1'b1;
      end
    end

    // Iteration stages, then the sign fix for folded angles, then rounding.
    always_ff @(posedge clk) begin
      x_q[0]    <= X_INIT;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip_in;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - CW'(atan_entry(TABLE_IDX_W'(i)));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + CW'(atan_entry(TABLE_IDX_W'(i)));
        end
        flip_q[i+1] <= flip_q[i];
      end
      xf_q         <= flip_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
      yf_q         <= flip_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
      trig_q.cos_v <= rnd_q30(xf_q);
      trig_q.sin_v <= rnd_q30(yf_q);
    end

    assign trig[l] = trig_q;
  end

endmodule

`default_nettype wire

/* design/eulr_mat.sv */
// ---------------------------------------------------------------------------
// eulr_mat
// Four-stage product pipeline forming R = Rz * Ry * Rx from the sines and
// cosines: pair products, triple products, sums, then rounding.
// ---------------------------------------------------------------------------
`default_nettype none

module eulr_mat
  import eulr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               vin,
  input  trig_t              trig [3],
  output logic               done,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22
);

  logic signed [15:0] sr, cr, sp, cp, sy, cy;

  // Stage A: pair products in Q2.28.
  logic signed [29:0] a_cpcy, a_cpsy, a_cpsr, a_cpcr;
  logic signed [29:0] a_cysp, a_crsy, a_crcy, a_srsy, a_crsp, a_cysr, a_spsr;
  logic signed [15:0] a_sr, a_sp, a_sy;

  // Stage B: triple products in Q3.42 and finished two-factor elements.
  logic signed [44:0] b_t01, b_t02, b_t11, b_t12;
  logic signed [29:0] b_crsy, b_srsy, b_crcy, b_cysr;
  logic signed [15:0] b_e00, b_e10, b_e20, b_e21, b_e22;

  // Stage C: full sums for the mixed elements.
  logic signed [45:0] c_s01, c_s02, c_s11, c_s12;
  logic signed [15:0] c_e00, c_e10, c_e20, c_e21, c_e22;

  logic va, vb, vc, vd;

  assign sr = trig[0].sin_v;
  assign cr = trig[0].cos_v;
  assign sp = trig[1].sin_v;
  assign cp = trig[1].cos_v;
  assign sy = trig[2].sin_v;
  assign cy = trig[2].cos_v;

  // Valid bits for the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= vin;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  assign done = vd;

  // Stage A: every pair product that any element needs.
  always_ff @(posedge clk) begin
    a_cpcy <= 30'(cp) * 30'(cy);
    a_cpsy <= 30'(cp) * 30'(sy);
    a_cpsr <= 30'(cp) * 30'(sr);
    a_cpcr <= 30'(cp) * 30'(cr);
    a_cysp <= 30'(cy) * 30'(sp);
    a_crsy <= 30'(cr) * 30'(sy);
    a_crcy <= 30'(cr) * 30'(cy);
    a_srsy <= 30'(sr) * 30'(sy);
    a_crsp <= 30'(cr) * 30'(sp);
    a_cysr <= 30'(cy) * 30'(sr);
    a_spsr <= 30'(sp) * 30'(sr);
    a_sr   <= sr;
    a_sp   <= sp;
    a_sy   <= sy;
  end

  // Stage B: triple products; the two-factor elements are rounded here.
  always_ff @(posedge clk) begin
    b_t01  <= 45'(a_cysp) * 45'(a_sr);
    b_t02  <= 45'(a_crcy) * 45'(a_sp);
    b_t11  <= 45'(a_spsr) * 45'(a_sy);
    b_t12  <= 45'(a_crsp) * 45'(a_sy);
    b_crsy <= a_crsy;
    b_srsy <= a_srsy;
    b_crcy <= a_crcy;
    b_cysr <= a_cysr;
    b_e00  <= rnd_q28(a_cpcy);
    b_e10  <= rnd_q28(a_cpsy);
    b_e21  <= rnd_q28(a_cpsr);
    b_e22  <= rnd_q28(a_cpcr);
    b_e20  <= sat_q14(-20'(a_sp));
  end

  // Stage C: pair terms are lifted to Q3.42 and combined with the triples.
  always_ff @(posedge clk) begin
    c_s01 <= 46'(b_t01) - (46'(b_crsy) <<< 14);
    c_s02 <= 46'(b_t02) + (46'(b_srsy) <<< 14);
    c_s11 <= (46'(b_crcy) <<< 14) + 46'(b_t11);
    c_s12 <= 46'(b_t12) - (46'(b_cysr) <<< 14);
    c_e00 <= b_e00;
    c_e10 <= b_e10;
    c_e20 <= b_e20;
    c_e21 <= b_e21;
    c_e22 <= b_e22;
  end

  // Stage D: output register with the final rounding of the mixed elements.
  always_ff @(posedge clk) begin
    m00 <= c_e00;
    m01 <= rnd_q42(c_s01);
    m02 <= rnd_q42(c_s02);
    m10 <= c_e10;
    m11 <= rnd_q42(c_s11);
    m12 <= rnd_q42(c_s12);
    m20 <= c_e20;
    m21 <= c_e21;
    m22 <= c_e22;
  end

endmodule

`default_nettype wire

/* design/eulr_check.sv */
// ---------------------------------------------------------------------------
// eulr_check
// Port-level checks on the rotation matrix block: reset behavior, fixed
// latency between an accepted word and its result, and output range.
// ---------------------------------------------------------------------------
`default_nettype none

module eulr_check
  import eulr_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] m00,
  input logic signed [15:0] m11,
  input logic signed [15:0] m20,
  input logic signed [15:0] m22
);

  // Edges from an accepted word to the edge that takes its result.
  localparam int LAT = CORDIC_STAGES + 7;

  // Reset flushes the pipeline, so no result follows it directly.
  a_rst_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every result strobe belongs to an earlier accepted word.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted word");

  // Diagonal and pitch elements stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (m00 <= ONE_Q14 && m00 >= -ONE_Q14 && m11 <= ONE_Q14 && m11 >= -ONE_Q14 &&
              m22 <= ONE_Q14 && m22 >= -ONE_Q14 && m20 <= ONE_Q14 && m20 >= -ONE_Q14))
    else $error("matrix element outside the Q1.14 unit range");

endmodule

bind euler_to_rotation_matrix eulr_check #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_eulr_check (.*);

`default_nettype wire

/* tb/rotation_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotation_checker
// Watches the angle and matrix channels of euler_to_rotation_matrix. For
// every accepted angle word it computes the expected z-y-x rotation matrix
// with its own CORDIC sine/cosine and fixed-point product model. It compares
// each delivered matrix, element by element, with the oldest expected one.
// ---------------------------------------------------------------------------
module rotation_checker
  import eulr_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic               done,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output int                 errors,
  output int                 pending
);

  localparam longint UNITY = 16384;
  localparam int     MAX_PRINTED = 100;

  // Nine Q1.14 elements, index 3*row+col.
  typedef logic [8:0][15:0] matrix_t;

  matrix_t expected_matrices[$];
  matrix_t want;
  matrix_t got;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic longint atan_turn(input int i);
    longint r;
    case (i)
      0:  r = 536870912;
      1:  r = 316933406;
      2:  r = 167458907;
      3:  r = 85004756;
      4:  r = 42667331;
      5:  r = 21354465;
      6:  r = 10679838;
      7:  r = 5340245;
      8:  r = 2670163;
      9:  r = 1335087;
      10: r = 667544;
      11: r = 333772;
      12: r = 166886;
      13: r = 83443;
      14: r = 41721;
      15: r = 20860;
      16: r = 10430;
      17: r = 5215;
      18: r = 2607;
      19: r = 1303;
      20: r = 651;
      21: r = 325;
      22: r = 162;
      23: r = 81;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint r;
    if (v > UNITY) r = UNITY;
    else if (v < -UNITY) r = -UNITY;
    else r = v;
    return r;
  endfunction

  // Round a value with frac fraction bits to Q1.14, half up, then clamp.
  function automatic longint round_to_q14(input longint v, input int frac);
    longint half;
    half = longint'(1) << (frac - 15);
    return clamp_unit((v + half) >>> (frac - 14));
  endfunction

  // Sine and cosine of one binary angle, Q1.14.
  task automatic sine_cosine(input logic signed [15:0] angle,
                             output longint s, output longint c);
    longint z, x, y, nx;
    int     n;
    bit     flip;
    z    = longint'(angle) * 65536;
    x    = 652032874;
    y    = 0;
    flip = 0;
    n    = (STAGES > 24) ? 24 : STAGES;
    // Fold angles beyond a quarter turn into the convergence range.
    if (z > (longint'(1) << 30)) begin
      z    = z - (longint'(1) << 31);
      flip = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z    = z + (longint'(1) << 31);
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_turn(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_turn(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_to_q14(x, 30);
    s = round_to_q14(y, 30);
  endtask

  // Expected Rz(yaw) * Ry(pitch) * Rx(roll).
  task automatic rotation_of(input logic signed [15:0] r_ang, p_ang, y_ang,
                             output matrix_t m);
    longint sr, cr, sp, cp, sy, cy;
    longint e [9];
    sine_cosine(r_ang, sr, cr);
    sine_cosine(p_ang, sp, cp);
    sine_cosine(y_ang, sy, cy);
    e[0] = round_to_q14(cp * cy, 28);
    e[1] = round_to_q14(cy * sp * sr - cr * sy * UNITY, 42);
    e[2] = round_to_q14(cr * cy * sp + sr * sy * UNITY, 42);
    e[3] = round_to_q14(cp * sy, 28);
    e[4] = round_to_q14(cr * cy * UNITY + sp * sr * sy, 42);
    e[5] = round_to_q14(cr * sp * sy - cy * sr * UNITY, 42);
    e[6] = clamp_unit(-sp);
    e[7] = round_to_q14(cp * sr, 28);
    e[8] = round_to_q14(cp * cr, 28);
    for (int k = 0; k < 9; k++) m[k] = e[k][15:0];
  endtask

  // One line per mismatch; printing stops after a while but counting goes on.
  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Record each accepted angle word and check each delivered matrix word.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        rotation_of(roll_angle, pitch_angle, yaw_angle, want);
        expected_matrices = {expected_matrices, want};
      end
      if (done) begin
        got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
        if (expected_matrices.size() == 0) begin
          report_mismatch("matrix word delivered with none outstanding");
        end else begin
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("m%0d%0d got %0d expected %0d",
                                        k / 3, k % 3, $signed(got[k]),
                                        $signed(want[k])));
            end
          end
        end
      end
      pending = expected_matrices.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives roll/pitch/yaw angle words into euler_to_rotation_matrix: a short
// directed set of extreme and fold-boundary angles, then random words with
// random gaps, bursts and drain pauses. The checker beside the block predicts
// and compares every matrix word; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench
  import eulr_pkg::*;
();

  localparam int STAGES       = CORDIC_STAGES_DEF;
  localparam int RANDOM_WORDS = 1600;
  localparam int DRAIN_CYCLES = STAGES + 12;
  localparam int CYCLE_LIMIT  = 500000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               done;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  int                 errors;
  int                 pending;
  int                 cycle_count;
  int                 burst_left;

  euler_to_rotation_matrix #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .done(done),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22)
  );

  rotation_checker #(.STAGES(STAGES)) u_rotation_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .done(done),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .errors(errors), .pending(pending)
  );

  // 125 MHz clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[euler_to_rotation_matrix] ERROR");
    $finish;
  end

  // Random angle, weighted toward the fold limits, zero and the half turn.
  function automatic logic signed [15:0] pick_angle();
    int v;
    case ($urandom_range(0, 9))
      5: begin
        v = 16384 + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) v = -v;
      end
      6: v = int'($urandom_range(0, 128)) - 64;
      7: begin
        if ($urandom_range(0, 1)) v = 32767 - int'($urandom_range(0, 3));
        else v = -32768 + int'($urandom_range(0, 3));
      end
      8: v = 8192 * int'($urandom_range(0, 7)) - 32768 + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom);
    endcase
    return 16'(v);
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Offer one angle word and return at the edge that takes it.
  task automatic send_word(input logic signed [15:0] r, p, y);
    @(negedge clk);
    start       = 1'b1;
    roll_angle  = r;
    pitch_angle = p;
    yaw_angle   = y;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold start low between words and put noise on the angle ports.
  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      start       = 1'b0;
      roll_angle  = 16'($urandom);
      pitch_angle = 16'($urandom);
      yaw_angle   = 16'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending until every outstanding matrix word has come back.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_directed(input logic signed [15:0] r, p, y);
    send_word(r, p, y);
    idle_for(pick_gap());
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    roll_angle  = '0;
    pitch_angle = '0;
    yaw_angle   = '0;
    burst_left  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: identity, extremes, quarter-turn fold edges, gimbal lock.
    send_directed(16'sd0, 16'sd0, 16'sd0);
    send_directed(-16'sd32768, -16'sd32768, -16'sd32768);
    send_directed(16'sd32767, 16'sd32767, 16'sd32767);
    send_directed(16'sd16384, 16'sd0, 16'sd0);
    send_directed(16'sd0, 16'sd16384, 16'sd0);
    send_directed(16'sd0, 16'sd0, 16'sd16384);
    send_directed(-16'sd16384, -16'sd16384, -16'sd16384);
    send_directed(16'sd16385, -16'sd16385, 16'sd16383);
    send_directed(-16'sd16383, 16'sd16383, -16'sd16385);
    send_directed(16'sd8192, 16'sd16384, -16'sd8192);
    send_directed(-16'sd12000, -16'sd16384, 16'sd5000);
    send_directed(16'sd8192, 16'sd8192, 16'sd8192);
    send_directed(16'sd1, -16'sd1, 16'sd1);
    send_directed(-16'sd32768, 16'sd16384, 16'sd32767);
    send_directed(16'sh5555, 16'shAAAA, 16'sh7FFF);
    send_directed(16'shAAAA, 16'sh5555, -16'sd32768);
    send_directed(-16'sd1, 16'sd32767, -16'sd32767);
    send_directed(16'sd24576, -16'sd24576, 16'sd4096);
    send_directed(-16'sd32767, 16'sd0, -16'sd32768);
    send_directed(16'sd16384, 16'sd16384, 16'sd16384);

    // Random words; two drain pauses, occasional zero-gap bursts.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3 || i == (2 * RANDOM_WORDS) / 3) wait_drained();
      send_word(pick_angle(), pick_angle(), pick_angle());
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 149) == 0) begin
        burst_left = 40;
      end else begin
        idle_for(pick_gap());
      end
    end

    // Drain the pipeline and give any stray word time to show.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("[euler_to_rotation_matrix] OK");
    end else begin
      $display("[euler_to_rotation_matrix] ERROR");
    end
    $finish;
  end

endmodule
